// File: src/lsh_pkg.sv
package lsh_pkg;

  // pixel and result widths
  localparam int PIX_W      = 8;
  localparam int SUM_W      = PIX_W + 2;
  localparam int RESP_W     = PIX_W + 5;

  // configuration register widths and port shape
  localparam int WIDTH_CFG_W  = 12;
  localparam int HEIGHT_CFG_W = 13;
  localparam int CFG_DATA_W   = 13;
  localparam int CFG_ADDR_W   = 2;

  // row counter runs 0 .. height + 1
  localparam int ROW_W      = 13;
  localparam int HEIGHT_MAX = 4096;
  localparam int DIM_MIN    = 3;

  localparam logic [PIX_W-1:0] PIX_MAX = '1;

  // reset values of the configuration registers
  localparam logic [WIDTH_CFG_W-1:0]  WIDTH_RST  = WIDTH_CFG_W'(640);
  localparam logic [HEIGHT_CFG_W-1:0] HEIGHT_RST = HEIGHT_CFG_W'(480);

  // register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_IMAGE_WIDTH  = 2'd0,
    CFG_IMAGE_HEIGHT = 2'd1,
    CFG_MASK_MODE    = 2'd2
  } cfg_idx_t;

  // Laplacian mask selection
  typedef enum logic {
    MASK_FOUR  = 1'b0,
    MASK_EIGHT = 1'b1
  } mask_t;

  typedef logic [PIX_W-1:0] pix_t;

  // control that travels with a word through the window stage
  typedef struct packed {
    logic valid;
    logic interior;
    logic last;
  } pos_ctl_t;

endpackage

// File: src/lsh_in_if.sv
interface lsh_in_if
  import lsh_pkg::*;
();
  logic valid;
  logic ready;
  pix_t pixel_in;
  logic flush;

  modport source (output valid, output pixel_in, output flush, input ready);
  modport sink   (input valid, input pixel_in, input flush, output ready);
endinterface

// File: src/lsh_out_if.sv
interface lsh_out_if
  import lsh_pkg::*;
();
  logic valid;
  logic ready;
  pix_t pixel_out;
  logic out_valid;
  logic frame_last;

  modport source (output valid, output pixel_out, output out_valid, output frame_last,
                  input ready);
  modport sink   (input valid, input pixel_out, input out_valid, input frame_last,
                  output ready);
endinterface

// File: src/lsh_ram.sv
module lsh_ram #(
  parameter int DATA_W = 16,
  parameter int DEPTH  = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_W-1:0]        wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  // single write port, registered read port (read-before-write)
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: src/laplacian_sharpen_3x3_top.sv
// 3x3 Laplacian sharpening, one word in and one word out per cycle while the output accepts.
// Result path: a word is registered in the window stage, then in the output register;
// the pixel it carries is the one from one row plus one pixel earlier in the stream.
// Throughput: one word per cycle while out_chan.ready holds, set by the registered line store read and window stage.
// Reset (rst_n low, synchronous): counters, window, stage flags and configuration
// return to their defaults; the line stores are not cleared.
module laplacian_sharpen_3x3_top
  import lsh_pkg::*;
#(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                  clk,
  input  logic                  rst_n,
  lsh_in_if.sink                in_chan,
  lsh_out_if.source             out_chan,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int IW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int XW = (CW > WIDTH_CFG_W) ? CW : WIDTH_CFG_W;

  // configuration registers
  logic [WIDTH_CFG_W-1:0]  width_r;
  logic [HEIGHT_CFG_W-1:0] height_r;
  mask_t                   mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
      mode_r   <= MASK_FOUR;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_addr))
        CFG_IMAGE_WIDTH:  width_r  <= cfg_wdata[WIDTH_CFG_W-1:0];
        CFG_IMAGE_HEIGHT: height_r <= cfg_wdata[HEIGHT_CFG_W-1:0];
        CFG_MASK_MODE:    mode_r   <= mask_t'(cfg_wdata[0]);
        default: ;
      endcase
    end
  end

  // effective dimensions, saturated to their legal ranges
  logic [XW-1:0]    w_ext;
  logic [CW-1:0]    w_eff;
  logic [ROW_W-1:0] h_eff;

  always_comb begin
    w_ext = XW'(width_r);
    if (w_ext < XW'(DIM_MIN)) begin
      w_ext = XW'(DIM_MIN);
    end else if (w_ext > XW'(MAX_WIDTH)) begin
      w_ext = XW'(MAX_WIDTH);
    end
    w_eff = w_ext[CW-1:0];
    h_eff = height_r;
    if (height_r < HEIGHT_CFG_W'(DIM_MIN)) begin
      h_eff = ROW_W'(DIM_MIN);
    end else if (height_r > HEIGHT_CFG_W'(HEIGHT_MAX)) begin
      h_eff = ROW_W'(HEIGHT_MAX);
    end
  end

  // handshake: window stage drains into the output register
  logic s1_vld_r, s1_vld_nxt;
  logic out_vld_r, out_vld_nxt;
  logic s1_go, s1_adv, in_rdy, accept;

  assign s1_go   = !out_vld_r || out_chan.ready;
  assign s1_adv  = s1_vld_r && s1_go;
  assign in_rdy  = !s1_vld_r || s1_go;
  assign accept  = in_chan.valid && in_rdy;
  assign in_chan.ready = in_rdy;

  // raster position and result position for the incoming word
  logic [CW-1:0]    col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [CW-1:0]    c0, qc, col_inc;
  logic [ROW_W-1:0] r0, qr;
  logic             q_vld, q_int, q_last;
  pos_ctl_t         ctl_nxt;

  always_comb begin
    c0 = col_r;
    r0 = row_r;
    if (c0 >= w_eff) begin
      c0 = '0;
      r0 = r0 + ROW_W'(1);
    end
    if (r0 > h_eff + ROW_W'(1)) begin
      r0 = h_eff + ROW_W'(1);
    end

    if (c0 != '0) begin
      q_vld = (r0 >= ROW_W'(1));
      qr    = q_vld ? r0 - ROW_W'(1) : r0;
      qc    = c0 - CW'(1);
    end else begin
      q_vld = (r0 >= ROW_W'(2));
      qr    = q_vld ? r0 - ROW_W'(2) : r0;
      qc    = w_eff - CW'(1);
    end
    if (qr > h_eff - ROW_W'(1)) begin
      q_vld = 1'b0;
    end

    q_int  = (qr >= ROW_W'(1)) && (qr <= h_eff - ROW_W'(2)) &&
             (qc >= CW'(1)) && (qc <= w_eff - CW'(2));
    q_last = q_vld && (qr == h_eff - ROW_W'(1)) && (qc == w_eff - CW'(1));

    ctl_nxt.valid    = q_vld;
    ctl_nxt.interior = q_int;
    ctl_nxt.last     = q_last;

    // advance the raster counters; a frame's last result restarts them
    col_inc = c0 + CW'(1);
    row_nxt = r0;
    if (q_last) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (col_inc >= w_eff) begin
      col_nxt = '0;
      row_nxt = r0 + ROW_W'(1);
    end else begin
      col_nxt = col_inc;
    end
    if (row_nxt > h_eff + ROW_W'(1)) begin
      row_nxt = h_eff + ROW_W'(1);
    end
  end

  // line stores: upper half holds the older row, lower half the newer row
  logic [IW-1:0]        rd_idx;
  logic [2*PIX_W-1:0]   ls_rdata;
  logic [2*PIX_W-1:0]   ls_wdata;
  logic [IW-1:0]        s1_idx_r;
  pix_t                 s1_px_r;
  pos_ctl_t             s1_ctl_r;
  pix_t                 a_eff, b_eff;
  logic                 fwd_r;
  pix_t                 fwd_a_r, fwd_b_r;
  pix_t                 px_in;

  assign rd_idx   = c0[IW-1:0];
  assign px_in    = in_chan.flush ? '0 : in_chan.pixel_in;
  assign ls_wdata = {a_eff, s1_px_r};

  lsh_ram #(
    .DATA_W (2 * PIX_W),
    .DEPTH  (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_idx_r),
    .wdata (ls_wdata),
    .re    (accept),
    .raddr (rd_idx),
    .rdata (ls_rdata)
  );

  // a frame restart can read the entry that the word ahead writes in the same cycle
  assign a_eff = fwd_r ? fwd_a_r : ls_rdata[PIX_W-1:0];
  assign b_eff = fwd_r ? fwd_b_r : ls_rdata[2*PIX_W-1:PIX_W];

  // window: column one and column two of the three rows (top, middle, bottom)
  pix_t win1_r [3];
  pix_t win2_r [3];

  // Laplacian response and sharpened pixel on the shifted window
  pix_t                     ctr;
  logic [SUM_W-1:0]         sum4, sumc, ctr4;
  logic signed [RESP_W-1:0] resp;
  pix_t                     resp_clamp;
  logic [PIX_W:0]           sharp;
  pix_t                     pix_nxt;

  always_comb begin
    ctr  = win2_r[1];
    ctr4 = {ctr, 2'b00};
    sum4 = SUM_W'(win2_r[0]) + SUM_W'(win2_r[2]) + SUM_W'(win1_r[1]) + SUM_W'(a_eff);
    sumc = SUM_W'(win1_r[0]) + SUM_W'(b_eff) + SUM_W'(win1_r[2]) + SUM_W'(s1_px_r);
    resp = $signed(RESP_W'(sum4)) - $signed(RESP_W'(ctr4));
    if (mode_r == MASK_EIGHT) begin
      resp = resp + $signed(RESP_W'(sumc)) - $signed(RESP_W'(ctr4));
    end
    if (!s1_ctl_r.interior || resp < 0) begin
      resp_clamp = '0;
    end else if (resp > $signed(RESP_W'(PIX_MAX))) begin
      resp_clamp = PIX_MAX;
    end else begin
      resp_clamp = resp[PIX_W-1:0];
    end
    sharp = {1'b0, ctr} + {1'b0, resp_clamp};
    if (!s1_ctl_r.valid) begin
      pix_nxt = '0;
    end else if (sharp[PIX_W]) begin
      pix_nxt = PIX_MAX;
    end else begin
      pix_nxt = sharp[PIX_W-1:0];
    end
  end

  // stage flags
  always_comb begin
    s1_vld_nxt = s1_vld_r;
    if (accept) begin
      s1_vld_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_vld_nxt = 1'b0;
    end
    out_vld_nxt = out_vld_r;
    if (s1_adv) begin
      out_vld_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r     <= '0;
      row_r     <= '0;
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      fwd_r     <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        win1_r[i] <= '0;
        win2_r[i] <= '0;
      end
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
      if (accept) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
        fwd_r <= s1_adv && (s1_idx_r == rd_idx);
      end
      if (s1_adv) begin
        for (int i = 0; i < 3; i++) begin
          win1_r[i] <= win2_r[i];
        end
        win2_r[0] <= b_eff;
        win2_r[1] <= a_eff;
        win2_r[2] <= s1_px_r;
      end
    end
  end

  // payload registers
  pix_t     out_pix_r;
  pos_ctl_t out_ctl_r;

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_idx_r <= rd_idx;
      s1_px_r  <= px_in;
      s1_ctl_r <= ctl_nxt;
      fwd_a_r  <= s1_px_r;
      fwd_b_r  <= a_eff;
    end
    if (s1_adv) begin
      out_pix_r <= pix_nxt;
      out_ctl_r <= s1_ctl_r;
    end
  end

  assign out_chan.valid      = out_vld_r;
  assign out_chan.pixel_out  = out_pix_r;
  assign out_chan.out_valid  = out_ctl_r.valid;
  assign out_chan.frame_last = out_ctl_r.last && out_ctl_r.valid;

endmodule
